/* src/mme_pkg.sv */
// Shared constants, codes and control structs of the matrix multiply engine.
package mme_pkg;

   localparam int MAX_DIM   = 8;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int DIM_W     = 4;
   localparam int FUNC_W    = 2;
   localparam int VALUE_W   = 16;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int SUM_W     = 35;
   localparam int CSR_IDX_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_STORE_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STORE_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] rows_a;
      logic [DIM_W-1:0] inner_dim;
      logic [DIM_W-1:0] cols_b;
   } dims_type;

   typedef struct packed {
      logic              store_a;
      logic              store_b;
      logic              issue;
      logic              first;
      logic              zero;
      logic              last_k;
      logic [ADDR_W-1:0] a_addr;
      logic [ADDR_W-1:0] b_addr;
      logic              emit;
      logic [IDX_W-1:0]  emit_row;
      logic [IDX_W-1:0]  emit_col;
      logic              emit_last;
   } cmd_type;

   typedef struct packed {
      logic sum_done;
      logic out_free;
   } status_type;

endpackage

/* src/mme_if.sv */
// Valid/ready channel interfaces for request and response transfers.
interface mme_req_if;
   logic                              valid;
   logic                              ready;
   logic [mme_pkg::FUNC_W-1:0]        func;
   logic [mme_pkg::IDX_W-1:0]         elem_row;
   logic [mme_pkg::IDX_W-1:0]         elem_col;
   logic signed [mme_pkg::VALUE_W-1:0] elem_value;

   modport source (output valid, func, elem_row, elem_col, elem_value, input ready);
   modport sink   (input valid, func, elem_row, elem_col, elem_value, output ready);
endinterface

interface mme_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mme_pkg::IDX_W-1:0]         out_row;
   logic [mme_pkg::IDX_W-1:0]         out_col;
   logic signed [mme_pkg::SUM_W-1:0]  out_value;
   logic                              last;

   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

/* src/mme_ctrl.sv */
// Sequencer: request decode and the row/column/inner-index walk of a product run.
module mme_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  mme_pkg::dims_type           dims,
   input  logic                        req_valid,
   input  logic [mme_pkg::FUNC_W-1:0]  req_func,
   output logic                        req_ready,
   input  mme_pkg::status_type         status,
   output mme_pkg::cmd_type            cmd
);
   import mme_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_WAIT,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] k_ff, k_in;

   logic accept;
   logic zero_inner;
   logic last_k;
   logic last_col;
   logic last_row;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign zero_inner = (dims.inner_dim == '0);
   assign last_k     = zero_inner || (k_ff + DIM_W'(1) == dims.inner_dim);
   assign last_col   = (j_ff + DIM_W'(1) == dims.cols_b);
   assign last_row   = (i_ff + DIM_W'(1) == dims.rows_a);

   always_comb begin
      cmd           = '0;
      cmd.store_a   = accept && (req_func == FUNC_STORE_A);
      cmd.store_b   = accept && (req_func == FUNC_STORE_B);
      cmd.issue     = (state_ff == ST_MAC);
      cmd.first     = (k_ff == '0);
      cmd.zero      = zero_inner;
      cmd.last_k    = last_k;
      cmd.a_addr    = {i_ff[IDX_W-1:0], k_ff[IDX_W-1:0]};
      cmd.b_addr    = {k_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
      cmd.emit      = (state_ff == ST_EMIT) && status.out_free;
      cmd.emit_row  = i_ff[IDX_W-1:0];
      cmd.emit_col  = j_ff[IDX_W-1:0];
      cmd.emit_last = last_row && last_col;
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_COMPUTE) &&
                (dims.rows_a != '0) && (dims.cols_b != '0)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (last_k) begin
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_WAIT: begin
            if (status.sum_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               k_in = '0;
               if (last_col && last_row) begin
                  state_in = ST_IDLE;
               end else if (last_col) begin
                  j_in     = '0;
                  i_in     = i_ff + DIM_W'(1);
                  state_in = ST_MAC;
               end else begin
                  j_in     = j_ff + DIM_W'(1);
                  state_in = ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

/* src/mme_datapath.sv */
// Element stores, multiply-accumulate pipeline and response output register.
module mme_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mme_pkg::cmd_type                    cmd,
   output mme_pkg::status_type                 status,
   input  logic [mme_pkg::IDX_W-1:0]           store_row,
   input  logic [mme_pkg::IDX_W-1:0]           store_col,
   input  logic signed [mme_pkg::VALUE_W-1:0]  store_value,
   mme_rsp_if.source                           rsp_chan
);
   import mme_pkg::*;

   logic signed [VALUE_W-1:0] a_mem [DEPTH];
   logic signed [VALUE_W-1:0] b_mem [DEPTH];

   logic signed [VALUE_W-1:0] a_rd_ff, b_rd_ff;
   logic                      s1_valid_ff, s1_first_ff, s1_zero_ff, s1_last_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic                      done_ff;

   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_row_ff, rsp_col_ff;
   logic signed [SUM_W-1:0]   rsp_value_ff;
   logic                      rsp_last_ff;

   logic [ADDR_W-1:0]         store_addr;

   assign store_addr = {store_row, store_col};

   always_ff @(posedge clock) begin
      if (cmd.store_a) begin
         a_mem[store_addr] <= store_value;
      end
      if (cmd.store_b) begin
         b_mem[store_addr] <= store_value;
      end
      if (cmd.issue) begin
         a_rd_ff <= a_mem[cmd.a_addr];
         b_rd_ff <= b_mem[cmd.b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_last_ff;
      end
   end

   always_comb begin
      acc_in = s2_first_ff ? '0 : acc_ff;
      acc_in = acc_in + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_zero_ff  <= cmd.zero;
      s1_last_ff  <= cmd.last_k;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= s1_zero_ff ? '0 : PROD_W'(a_rd_ff * b_rd_ff);
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_row_ff   <= cmd.emit_row;
         rsp_col_ff   <= cmd.emit_col;
         rsp_value_ff <= acc_ff;
         rsp_last_ff  <= cmd.emit_last;
      end
   end

   assign status.sum_done = done_ff;
   assign status.out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.last      = rsp_last_ff;

   emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result loaded over a pending transfer");

   sum_after_last_issue: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && cmd.last_k) |-> ##3 done_ff)
      else $error("accumulation did not finish three cycles after final issue");

   done_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!s2_valid_ff && !s1_valid_ff))
      else $error("new issue overlapped a finished sum");

endmodule

/* src/matrix_multiply_engine_top.sv */
// Top level of the matrix multiply engine: size registers and unit wiring.
//
// Usage:
//   req_chan carries one item per transfer: func 0 stores elem_value into
//   A(elem_row, elem_col), func 1 into B(elem_row, elem_col), func 2 starts a
//   product run, func 3 is dropped. Stores are taken back to back. A product
//   run emits rows_a * cols_b transfers on rsp_chan in row-major order, last
//   set on the final one; req_chan is not ready during the run.
//   Each product element takes inner_dim inner steps (one for inner_dim of
//   zero), one inner step per cycle through the single shared
//   multiply-accumulate pipeline (registered store read, multiply,
//   accumulate); the pipeline then drains and the sum is loaded into the
//   output register.
//   csr_we writes rows_a, inner_dim or cols_b (index 0, 1, 2), clamped to 8;
//   write only while idle. Reset sets all sizes to 8 and clears the control
//   state; store contents stay undefined until written.
//   A stalled receiver holds the result in the output register; the run
//   computes the next element, then pauses until the transfer completes.
module matrix_multiply_engine_top (
   input  logic                            clock,
   input  logic                            reset,
   mme_req_if.sink                         req_chan,
   mme_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mme_pkg::DIM_W-1:0]       csr_wdata
);
   import mme_pkg::*;

   dims_type         dims_ff;
   logic [DIM_W-1:0] clamped;
   cmd_type          cmd;
   status_type       status;
   logic             ctrl_ready;

   assign clamped = (csr_wdata > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.rows_a    <= DIM_W'(MAX_DIM);
         dims_ff.inner_dim <= DIM_W'(MAX_DIM);
         dims_ff.cols_b    <= DIM_W'(MAX_DIM);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_A:    dims_ff.rows_a    <= clamped;
            CSR_INNER_DIM: dims_ff.inner_dim <= clamped;
            CSR_COLS_B:    dims_ff.cols_b    <= clamped;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = ctrl_ready;

   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims_ff),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mme_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .store_row   (req_chan.elem_row),
      .store_col   (req_chan.elem_col),
      .store_value (req_chan.elem_value),
      .rsp_chan    (rsp_chan)
   );

endmodule
